>>> rtl/core/des_ffrk_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// DES fixed round key package
// Permutation tables, S-boxes and round function shared by the cipher and its cells.
// ----------------------------------------------------------------------------
package des_ffrk_pkg;

  localparam int unsigned NumRoundsDefault = 16;
  localparam int unsigned BlockW = 64;
  localparam int unsigned HalfW  = 32;
  localparam int unsigned KeyW   = 48;

  typedef logic [7:0] tab_entry_t;

  localparam tab_entry_t IP_TAB [64] = '{
    8'd58, 8'd50, 8'd42, 8'd34, 8'd26, 8'd18, 8'd10, 8'd2,
    8'd60, 8'd52, 8'd44, 8'd36, 8'd28, 8'd20, 8'd12, 8'd4,
    8'd62, 8'd54, 8'd46, 8'd38, 8'd30, 8'd22, 8'd14, 8'd6,
    8'd64, 8'd56, 8'd48, 8'd40, 8'd32, 8'd24, 8'd16, 8'd8,
    8'd57, 8'd49, 8'd41, 8'd33, 8'd25, 8'd17, 8'd9,  8'd1,
    8'd59, 8'd51, 8'd43, 8'd35, 8'd27, 8'd19, 8'd11, 8'd3,
    8'd61, 8'd53, 8'd45, 8'd37, 8'd29, 8'd21, 8'd13, 8'd5,
    8'd63, 8'd55, 8'd47, 8'd39, 8'd31, 8'd23, 8'd15, 8'd7};

  localparam tab_entry_t FP_TAB [64] = '{
    8'd40, 8'd8, 8'd48, 8'd16, 8'd56, 8'd24, 8'd64, 8'd32,
    8'd39, 8'd7, 8'd47, 8'd15, 8'd55, 8'd23, 8'd63, 8'd31,
    8'd38, 8'd6, 8'd46, 8'd14, 8'd54, 8'd22, 8'd62, 8'd30,
    8'd37, 8'd5, 8'd45, 8'd13, 8'd53, 8'd21, 8'd61, 8'd29,
    8'd36, 8'd4, 8'd44, 8'd12, 8'd52, 8'd20, 8'd60, 8'd28,
    8'd35, 8'd3, 8'd43, 8'd11, 8'd51, 8'd19, 8'd59, 8'd27,
    8'd34, 8'd2, 8'd42, 8'd10, 8'd50, 8'd18, 8'd58, 8'd26,
    8'd33, 8'd1, 8'd41, 8'd9,  8'd49, 8'd17, 8'd57, 8'd25};

  localparam tab_entry_t E_TAB [48] = '{
    8'd32, 8'd1,  8'd2,  8'd3,  8'd4,  8'd5,  8'd4,  8'd5,
    8'd6,  8'd7,  8'd8,  8'd9,  8'd8,  8'd9,  8'd10, 8'd11,
    8'd12, 8'd13, 8'd12, 8'd13, 8'd14, 8'd15, 8'd16, 8'd17,
    8'd16, 8'd17, 8'd18, 8'd19, 8'd20, 8'd21, 8'd20, 8'd21,
    8'd22, 8'd23, 8'd24, 8'd25, 8'd24, 8'd25, 8'd26, 8'd27,
    8'd28, 8'd29, 8'd28, 8'd29, 8'd30, 8'd31, 8'd32, 8'd1};

  localparam tab_entry_t P_TAB [32] = '{
    8'd16, 8'd7,  8'd20, 8'd21, 8'd29, 8'd12, 8'd28, 8'd17,
    8'd1,  8'd15, 8'd23, 8'd26, 8'd5,  8'd18, 8'd31, 8'd10,
    8'd2,  8'd8,  8'd24, 8'd14, 8'd32, 8'd27, 8'd3,  8'd9,
    8'd19, 8'd13, 8'd30, 8'd6,  8'd22, 8'd11, 8'd4,  8'd25};

  typedef logic [3:0] nib_t;

  localparam nib_t SBOX [8][64] = '{
    '{4'd14,4'd4,4'd13,4'd1,4'd2,4'd15,4'd11,4'd8,4'd3,4'd10,4'd6,4'd12,4'd5,4'd9,4'd0,4'd7,
      4'd0,4'd15,4'd7,4'd4,4'd14,4'd2,4'd13,4'd1,4'd10,4'd6,4'd12,4'd11,4'd9,4'd5,4'd3,4'd8,
      4'd4,4'd1,4'd14,4'd8,4'd13,4'd6,4'd2,4'd11,4'd15,4'd12,4'd9,4'd7,4'd3,4'd10,4'd5,4'd0,
      4'd15,4'd12,4'd8,4'd2,4'd4,4'd9,4'd1,4'd7,4'd5,4'd11,4'd3,4'd14,4'd10,4'd0,4'd6,4'd13},
    '{4'd15,4'd1,4'd8,4'd14,4'd6,4'd11,4'd3,4'd4,4'd9,4'd7,4'd2,4'd13,4'd12,4'd0,4'd5,4'd10,
      4'd3,4'd13,4'd4,4'd7,4'd15,4'd2,4'd8,4'd14,4'd12,4'd0,4'd1,4'd10,4'd6,4'd9,4'd11,4'd5,
      4'd0,4'd14,4'd7,4'd11,4'd10,4'd4,4'd13,4'd1,4'd5,4'd8,4'd12,4'd6,4'd9,4'd3,4'd2,4'd15,
      4'd13,4'd8,4'd10,4'd1,4'd3,4'd15,4'd4,4'd2,4'd11,4'd6,4'd7,4'd12,4'd0,4'd5,4'd14,4'd9},
    '{4'd10,4'd0,4'd9,4'd14,4'd6,4'd3,4'd15,4'd5,4'd1,4'd13,4'd12,4'd7,4'd11,4'd4,4'd2,4'd8,
      4'd13,4'd7,4'd0,4'd9,4'd3,4'd4,4'd6,4'd10,4'd2,4'd8,4'd5,4'd14,4'd12,4'd11,4'd15,4'd1,
      4'd13,4'd6,4'd4,4'd9,4'd8,4'd15,4'd3,4'd0,4'd11,4'd1,4'd2,4'd12,4'd5,4'd10,4'd14,4'd7,
      4'd1,4'd10,4'd13,4'd0,4'd6,4'd9,4'd8,4'd7,4'd4,4'd15,4'd14,4'd3,4'd11,4'd5,4'd2,4'd12},
    '{4'd7,4'd13,4'd14,4'd3,4'd0,4'd6,4'd9,4'd10,4'd1,4'd2,4'd8,4'd5,4'd11,4'd12,4'd4,4'd15,
      4'd13,4'd8,4'd11,4'd5,4'd6,4'd15,4'd0,4'd3,4'd4,4'd7,4'd2,4'd12,4'd1,4'd10,4'd14,4'd9,
      4'd10,4'd6,4'd9,4'd0,4'd12,4'd11,4'd7,4'd13,4'd15,4'd1,4'd3,4'd14,4'd5,4'd2,4'd8,4'd4,
      4'd3,4'd15,4'd0,4'd6,4'd10,4'd1,4'd13,4'd8,4'd9,4'd4,4'd5,4'd11,4'd12,4'd7,4'd2,4'd14},
    '{4'd2,4'd12,4'd4,4'd1,4'd7,4'd10,4'd11,4'd6,4'd8,4'd5,4'd3,4'd15,4'd13,4'd0,4'd14,4'd9,
      4'd14,4'd11,4'd2,4'd12,4'd4,4'd7,4'd13,4'd1,4'd5,4'd0,4'd15,4'd10,4'd3,4'd9,4'd8,4'd6,
      4'd4,4'd2,4'd1,4'd11,4'd10,4'd13,4'd7,4'd8,4'd15,4'd9,4'd12,4'd5,4'd6,4'd3,4'd0,4'd14,
      4'd11,4'd8,4'd12,4'd7,4'd1,4'd14,4'd2,4'd13,4'd6,4'd15,4'd0,4'd9,4'd10,4'd4,4'd5,4'd3},
    '{4'd12,4'd1,4'd10,4'd15,4'd9,4'd2,4'd6,4'd8,4'd0,4'd13,4'd3,4'd4,4'd14,4'd7,4'd5,4'd11,
      4'd10,4'd15,4'd4,4'd2,4'd7,4'd12,4'd9,4'd5,4'd6,4'd1,4'd13,4'd14,4'd0,4'd11,4'd3,4'd8,
      4'd9,4'd14,4'd15,4'd5,4'd2,4'd8,4'd12,4'd3,4'd7,4'd0,4'd4,4'd10,4'd1,4'd13,4'd11,4'd6,
      4'd4,4'd3,4'd2,4'd12,4'd9,4'd5,4'd15,4'd10,4'd11,4'd14,4'd1,4'd7,4'd6,4'd0,4'd8,4'd13},
    '{4'd4,4'd11,4'd2,4'd14,4'd15,4'd0,4'd8,4'd13,4'd3,4'd12,4'd9,4'd7,4'd5,4'd10,4'd6,4'd1,
      4'd13,4'd0,4'd11,4'd7,4'd4,4'd9,4'd1,4'd10,4'd14,4'd3,4'd5,4'd12,4'd2,4'd15,4'd8,4'd6,
      4'd1,4'd4,4'd11,4'd13,4'd12,4'd3,4'd7,4'd14,4'd10,4'd15,4'd6,4'd8,4'd0,4'd5,4'd9,4'd2,
      4'd6,4'd11,4'd13,4'd8,4'd1,4'd4,4'd10,4'd7,4'd9,4'd5,4'd0,4'd15,4'd14,4'd2,4'd3,4'd12},
    '{4'd13,4'd2,4'd8,4'd4,4'd6,4'd15,4'd11,4'd1,4'd10,4'd9,4'd3,4'd14,4'd5,4'd0,4'd12,4'd7,
      4'd1,4'd15,4'd13,4'd8,4'd10,4'd3,4'd7,4'd4,4'd12,4'd5,4'd6,4'd11,4'd0,4'd14,4'd9,4'd2,
      4'd7,4'd11,4'd4,4'd1,4'd9,4'd12,4'd14,4'd2,4'd0,4'd6,4'd10,4'd13,4'd15,4'd3,4'd5,4'd8,
      4'd2,4'd1,4'd14,4'd7,4'd4,4'd10,4'd8,4'd13,4'd15,4'd12,4'd9,4'd0,4'd3,4'd5,4'd6,4'd11}};

  function automatic logic [BlockW-1:0] perm64(input logic [BlockW-1:0] x,
                                               input tab_entry_t tab [64]);
    logic [BlockW-1:0] r;
    logic [5:0] idx;
    for (int k = 0; k < 64; k++) begin
      idx = 6'(8'd64 - tab[k]);
      r[63-k] = x[idx];
    end
    return r;
  endfunction

  function automatic logic [HalfW-1:0] feistel(input logic [HalfW-1:0] rh,
                                               input logic [KeyW-1:0] key);
    logic [KeyW-1:0] x;
    logic [HalfW-1:0] s;
    logic [HalfW-1:0] p;
    logic [5:0] ch;
    logic [4:0] idx;
    for (int k = 0; k < 48; k++) begin
      idx = 5'(8'd32 - E_TAB[k]);
      x[47-k] = rh[idx];
    end
    x = x ^ key;
    for (int b = 0; b < 8; b++) begin
      ch = x[47-6*b -: 6];
      s[31-4*b -: 4] = SBOX[b][{ch[5], ch[0], ch[4:1]}];
    end
    for (int k = 0; k < 32; k++) begin
      idx = 5'(8'd32 - P_TAB[k]);
      p[31-k] = s[idx];
    end
    return p;
  endfunction

endpackage

>>> rtl/core/des_ffrk_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// DES fixed round key cell
// One Feistel round with a register stage; swaps halves unless last.
// ----------------------------------------------------------------------------
module des_ffrk_cell #(
  parameter bit LastRound = 1'b0
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          en_i,
  input  logic                          valid_i,
  input  logic [des_ffrk_pkg::BlockW-1:0] blk_i,
  input  logic [des_ffrk_pkg::KeyW-1:0]   key_i,
  output logic                          valid_o,
  output logic [des_ffrk_pkg::BlockW-1:0] blk_o
);
  import des_ffrk_pkg::*;

  logic [HalfW-1:0] mixed;
  logic [BlockW-1:0] blk_d, blk_q;
  logic valid_q;

  assign mixed = blk_i[63:32] ^ feistel(blk_i[31:0], key_i);
  assign blk_d = LastRound ? {mixed, blk_i[31:0]} : {blk_i[31:0], mixed};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      blk_q <= blk_d;
    end
  end

  assign valid_o = valid_q;
  assign blk_o   = blk_q;
endmodule

>>> rtl/core/des_feistel_fixed_round_key.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// DES fixed round key cipher
// Initial permutation, a chain of round cells, final permutation.
// ----------------------------------------------------------------------------
//  channel  signals                            dir
//  in       in_valid_i in_stall_o data_block_i  in
//  out      out_valid_o out_stall_i result_block_o  out
//  cfg      cfg_we_i cfg_wdata_i                 in
// One word per cycle while the output does not stall; one register per round cell.
// The chain advances as a whole whenever the last cell is empty or its word
// is taken, so a stall on the output holds every cell. Reset empties the chain
// and clears the key.
module des_feistel_fixed_round_key #(
  parameter int unsigned NUM_ROUNDS = des_ffrk_pkg::NumRoundsDefault
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [des_ffrk_pkg::KeyW-1:0]   cfg_wdata_i,
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  logic [des_ffrk_pkg::BlockW-1:0] data_block_i,
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output logic [des_ffrk_pkg::BlockW-1:0] result_block_o
);
  import des_ffrk_pkg::*;

  logic [KeyW-1:0] key_q;
  logic            en;
  logic            vld [NUM_ROUNDS+1];
  logic [BlockW-1:0] blk [NUM_ROUNDS+1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_q <= '0;
    end else if (cfg_we_i) begin
      key_q <= cfg_wdata_i;
    end
  end

  assign en         = !(vld[NUM_ROUNDS] && out_stall_i);
  assign in_stall_o = !en;
  assign vld[0]     = in_valid_i;
  assign blk[0]     = perm64(data_block_i, IP_TAB);

  for (genvar g = 0; g < NUM_ROUNDS; g++) begin : g_cell
    des_ffrk_cell #(.LastRound(g == NUM_ROUNDS - 1)) u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .en_i   (en),
      .valid_i(vld[g]),
      .blk_i  (blk[g]),
      .key_i  (key_q),
      .valid_o(vld[g+1]),
      .blk_o  (blk[g+1])
    );
  end

  assign out_valid_o    = vld[NUM_ROUNDS];
  assign result_block_o = perm64(blk[NUM_ROUNDS], FP_TAB);
endmodule
